### hw/rtl/ihrp_pkg.sv
// Shared types, codes and helpers for the hex record parser.
package ihrp_pkg;

	typedef logic [1:0] req_t;
	typedef logic [2:0] kind_t;

	localparam req_t REQ_CHAR    = 2'd0;
	localparam req_t REQ_END     = 2'd1;
	localparam req_t REQ_RESTART = 2'd2;

	localparam kind_t KIND_WRITE  = 3'd0;
	localparam kind_t KIND_START  = 3'd1;
	localparam kind_t KIND_DONE   = 3'd2;
	localparam kind_t KIND_FORMAT = 3'd3;
	localparam kind_t KIND_CHKSUM = 3'd4;
	localparam kind_t KIND_EARLY  = 3'd5;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;

	localparam logic [7:0] REC_DATA  = 8'h00;
	localparam logic [7:0] REC_EOF   = 8'h01;
	localparam logic [7:0] REC_START = 8'h05;
	localparam logic [7:0] START_LEN = 8'd4;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	// ASCII hex digit, either case
	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.nib = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.nib = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.nib = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.nib = 4'(c - 8'h57);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

### hw/rtl/ihrp_if.sv
// Handshake channels for character items and result items.
interface ihrp_in_if;
	logic               valid;
	logic               ready;
	ihrp_pkg::req_t     req_type;
	logic [7:0]         char_code;

	modport source(output valid, req_type, char_code, input ready);
	modport sink(input valid, req_type, char_code, output ready);
endinterface

interface ihrp_out_if;
	logic               valid;
	logic               ready;
	ihrp_pkg::kind_t    res_kind;
	logic [15:0]        mem_address;
	logic [7:0]         mem_data;
	logic [31:0]        start_address;

	modport source(output valid, res_kind, mem_address, mem_data, start_address, input ready);
	modport sink(input valid, res_kind, mem_address, mem_data, start_address, output ready);
endinterface

### hw/rtl/intel_hex_record_parser.sv
// Intel HEX record parser: one character item in, at most one result item out.
//
// feed carries one request per item: a character, end of input, or restart.
// result carries data writes (address, byte), the 32-bit start address of a
// type 05 record, and the terminal kinds: load complete, format error,
// checksum error and input ended early.
// Every item is decoded in the cycle it is accepted; its result, if any, sits
// in the output register from the next cycle on.
// Throughput is one item per cycle: feed.ready is high whenever the output
// register is empty or being drained this cycle.
// When the receiver stalls with a result waiting, feed.ready drops until that
// result is taken; items that cause no result are stalled as well.
// After a terminal result everything but restart is ignored without output.
// Reset (arst_n low) clears the parser to waiting for ':' and empties the
// output register; a restart item does the same to the parser alone.
module intel_hex_record_parser (
	input  logic               clk,
	input  logic               arst_n,
	ihrp_in_if.sink            feed,
	ihrp_out_if.source         result
);

	localparam logic [2:0] PH_COLON    = 3'd0;
	localparam logic [2:0] PH_COUNT    = 3'd1;
	localparam logic [2:0] PH_ADDR     = 3'd2;
	localparam logic [2:0] PH_TYPE     = 3'd3;
	localparam logic [2:0] PH_DATA     = 3'd4;
	localparam logic [2:0] PH_CHECK    = 3'd5;
	localparam logic [2:0] PH_TERM     = 3'd6;
	localparam logic [2:0] PH_AFTER_CR = 3'd7;

	logic [2:0]  phase_q, phase_d;
	logic        hi_seen_q, hi_seen_d;
	logic [3:0]  partial_q, partial_d;
	logic [7:0]  idx_q, idx_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  len_q, len_d;
	logic [15:0] addr_q, addr_d;
	logic [7:0]  rkind_q, rkind_d;
	logic [31:0] accum_q, accum_d;
	logic        done_q, done_d;

	logic                 res_vld;
	ihrp_pkg::kind_t      res_kind_d;
	logic [15:0]          mem_addr_d;
	logic [7:0]           mem_data_d;
	logic [31:0]          start_d;

	logic                 out_valid_q;
	ihrp_pkg::kind_t      kind_q;
	logic [15:0]          mem_addr_q;
	logic [7:0]           mem_data_q;
	logic [31:0]          start_q;

	ihrp_pkg::hex_t       hx;
	logic [7:0]           byte_v;
	logic [16:0]          wr_addr;
	logic [8:0]           idx_inc;
	logic                 accept;

	assign accept     = feed.valid && feed.ready;
	assign feed.ready = !out_valid_q || result.ready;

	assign hx      = ihrp_pkg::hex_digit(feed.char_code);
	assign byte_v  = {partial_q, hx.nib};
	assign wr_addr = {1'b0, addr_q} + {9'd0, idx_q};
	assign idx_inc = {1'b0, idx_q} + 9'd1;

	always_comb begin
		phase_d    = phase_q;
		hi_seen_d  = hi_seen_q;
		partial_d  = partial_q;
		idx_d      = idx_q;
		sum_d      = sum_q;
		len_d      = len_q;
		addr_d     = addr_q;
		rkind_d    = rkind_q;
		accum_d    = accum_q;
		done_d     = done_q;
		res_vld    = 1'b0;
		res_kind_d = ihrp_pkg::KIND_FORMAT;
		mem_addr_d = 16'd0;
		mem_data_d = 8'd0;
		start_d    = 32'd0;

		if (feed.req_type == ihrp_pkg::REQ_RESTART) begin
			phase_d   = PH_COLON;
			hi_seen_d = 1'b0;
			partial_d = 4'd0;
			idx_d     = 8'd0;
			sum_d     = 8'd0;
			len_d     = 8'd0;
			addr_d    = 16'd0;
			rkind_d   = 8'd0;
			accum_d   = 32'd0;
			done_d    = 1'b0;
		end else if (done_q) begin
			// finished: wait for restart
		end else if (feed.req_type == ihrp_pkg::REQ_END) begin
			res_vld    = 1'b1;
			res_kind_d = ihrp_pkg::KIND_EARLY;
		end else if (feed.req_type == ihrp_pkg::REQ_CHAR) begin
			unique case (phase_q)
				PH_COLON: begin
					if (feed.char_code != ihrp_pkg::CHAR_COLON) begin
						res_vld = 1'b1;
					end else begin
						sum_d     = 8'd0;
						addr_d    = 16'd0;
						hi_seen_d = 1'b0;
						partial_d = 4'd0;
						phase_d   = PH_COUNT;
					end
				end
				PH_TERM: begin
					phase_d = (feed.char_code == ihrp_pkg::CHAR_CR) ? PH_AFTER_CR : PH_COLON;
				end
				PH_AFTER_CR: begin
					phase_d = PH_COLON;
				end
				default: begin
					if (!hx.ok) begin
						res_vld = 1'b1;
					end else if (!hi_seen_q) begin
						partial_d = hx.nib;
						hi_seen_d = 1'b1;
					end else begin
						hi_seen_d = 1'b0;
						partial_d = 4'd0;
						unique case (phase_q)
							PH_COUNT: begin
								sum_d   = sum_q + byte_v;
								len_d   = byte_v;
								idx_d   = 8'd0;
								phase_d = PH_ADDR;
							end
							PH_ADDR: begin
								sum_d  = sum_q + byte_v;
								addr_d = {addr_q[7:0], byte_v};
								idx_d  = idx_inc[7:0];
								if (idx_inc >= 9'd2) begin
									phase_d = PH_TYPE;
								end
							end
							PH_TYPE: begin
								sum_d   = sum_q + byte_v;
								rkind_d = byte_v;
								idx_d   = 8'd0;
								if (byte_v == ihrp_pkg::REC_DATA) begin
									phase_d = (len_q == 8'd0) ? PH_CHECK : PH_DATA;
								end else if (byte_v == ihrp_pkg::REC_EOF) begin
									phase_d = PH_CHECK;
								end else if (byte_v == ihrp_pkg::REC_START &&
										len_q == ihrp_pkg::START_LEN) begin
									accum_d = 32'd0;
									phase_d = PH_DATA;
								end else begin
									res_vld = 1'b1;
								end
							end
							PH_DATA: begin
								sum_d = sum_q + byte_v;
								if (rkind_q == ihrp_pkg::REC_DATA) begin
									// bytes past the top of the address space are dropped
									if (!wr_addr[16]) begin
										res_vld    = 1'b1;
										res_kind_d = ihrp_pkg::KIND_WRITE;
										mem_addr_d = wr_addr[15:0];
										mem_data_d = byte_v;
									end
								end else begin
									accum_d = {accum_q[23:0], byte_v};
									if (idx_q == 8'd3) begin
										res_vld    = 1'b1;
										res_kind_d = ihrp_pkg::KIND_START;
										start_d    = {accum_q[23:0], byte_v};
									end
								end
								idx_d = idx_inc[7:0];
								if (idx_inc >= {1'b0, len_q}) begin
									phase_d = PH_CHECK;
								end
							end
							PH_CHECK: begin
								if (byte_v != 8'(8'd0 - sum_q)) begin
									res_vld    = 1'b1;
									res_kind_d = ihrp_pkg::KIND_CHKSUM;
								end else if (rkind_q == ihrp_pkg::REC_EOF ||
										(rkind_q == ihrp_pkg::REC_DATA && len_q == 8'd0)) begin
									res_vld    = 1'b1;
									res_kind_d = ihrp_pkg::KIND_DONE;
								end else begin
									phase_d = PH_TERM;
								end
							end
							default: begin
								res_vld = 1'b1;
							end
						endcase
					end
				end
			endcase
			// any terminal result ends the load
			if (res_vld && res_kind_d != ihrp_pkg::KIND_WRITE &&
					res_kind_d != ihrp_pkg::KIND_START) begin
				done_d = 1'b1;
			end
		end
		if (feed.req_type == ihrp_pkg::REQ_END && !done_q) begin
			done_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_COLON;
			hi_seen_q <= 1'b0;
			partial_q <= 4'd0;
			idx_q     <= 8'd0;
			sum_q     <= 8'd0;
			len_q     <= 8'd0;
			addr_q    <= 16'd0;
			rkind_q   <= 8'd0;
			accum_q   <= 32'd0;
			done_q    <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			hi_seen_q <= hi_seen_d;
			partial_q <= partial_d;
			idx_q     <= idx_d;
			sum_q     <= sum_d;
			len_q     <= len_d;
			addr_q    <= addr_d;
			rkind_q   <= rkind_d;
			accum_q   <= accum_d;
			done_q    <= done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && res_vld) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_vld) begin
			kind_q     <= res_kind_d;
			mem_addr_q <= mem_addr_d;
			mem_data_q <= mem_data_d;
			start_q    <= start_d;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.res_kind      = kind_q;
	assign result.mem_address   = mem_addr_q;
	assign result.mem_data      = mem_data_q;
	assign result.start_address = start_q;

endmodule

### hw/rtl/ihrp_checker.sv
// Port-level checks for the hex record parser, bound to the top level.
module ihrp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input ihrp_pkg::kind_t     res_kind,
	input logic [15:0]         mem_address,
	input logic [7:0]          mem_data,
	input logic [31:0]         start_address
);

	logic terminal;
	assign terminal = res_kind != ihrp_pkg::KIND_WRITE && res_kind != ihrp_pkg::KIND_START;

	// a waiting result item is held until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_kind))
		else $error("result item dropped while stalled");

	// write fields are zero on every non-write item
	a_wr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_kind != ihrp_pkg::KIND_WRITE |-> mem_address == 16'd0 && mem_data == 8'd0)
		else $error("write fields set on non-write item");

	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_kind != ihrp_pkg::KIND_START |-> start_address == 32'd0)
		else $error("start address set on non-start item");

	// nothing can follow a terminal item without a restart in between
	a_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && terminal |=> !out_valid)
		else $error("result item right after a terminal item");

endmodule

bind intel_hex_record_parser ihrp_checker u_ihrp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.res_kind      (result.res_kind),
	.mem_address   (result.mem_address),
	.mem_data      (result.mem_data),
	.start_address (result.start_address)
);
